FILE: src/rfdw_pkg.sv
// Shared types and constants of the RF packet duplicate filter and watchdog
`default_nettype none
package rfdw_pkg;

    localparam int SERIAL_W  = 20;
    localparam int STATUS_W  = 8;
    localparam int RSSI_W    = 8;
    localparam int TIME_W    = 48;
    localparam int STATE_W   = 8;
    localparam int WINDOW_W  = 32;
    localparam int WDOG_W    = 40;
    localparam int ACTION_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 40;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_IDLE   = 3'd0,
        ACT_WEAK   = 3'd1,
        ACT_DUP    = 3'd2,
        ACT_FWD    = 3'd3,
        ACT_REINIT = 3'd4,
        ACT_KICK   = 3'd5
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RSSI_THR  = 3'd0,
        REG_BURST_WIN = 3'd1,
        REG_LONG_WIN  = 3'd2,
        REG_WDOG      = 3'd3,
        REG_WDOG_EN   = 3'd4,
        REG_RX_STATE  = 3'd5
    } cfg_reg_t;

    localparam logic signed [RSSI_W-1:0] RST_RSSI_THR  = -8'sd100;
    localparam logic [WINDOW_W-1:0]      RST_BURST_WIN = 32'd300000;
    localparam logic [WINDOW_W-1:0]      RST_LONG_WIN  = 32'd2500000;
    localparam logic [WDOG_W-1:0]        RST_WDOG      = 40'd5400000000;
    localparam logic                     RST_WDOG_EN   = 1'b1;
    localparam logic [STATE_W-1:0]       RST_RX_STATE  = 8'd13;

    typedef struct packed {
        logic signed [RSSI_W-1:0] rssi_threshold;
        logic [WINDOW_W-1:0]      burst_window_us;
        logic [WINDOW_W-1:0]      long_window_us;
        logic [WDOG_W-1:0]        watchdog_us;
        logic                     watchdog_enable;
        logic [STATE_W-1:0]       rx_state_code;
    } cfg_t;

    typedef struct packed {
        logic                     scan;
        action_t                  act;
        logic [SERIAL_W-1:0]      serial;
        logic [STATUS_W-1:0]      status;
        logic signed [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0]        now_us;
    } job_t;

    typedef struct packed {
        logic [SERIAL_W-1:0] serial;
        logic [STATUS_W-1:0] status;
        logic [TIME_W-1:0]   stamp;
    } hist_t;

endpackage
`default_nettype wire

FILE: src/rfdw_front.sv
// Front end: accepts requests, flags weak packets, resolves health ticks, queues jobs
`default_nettype none
module rfdw_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              req_type,
    input  wire logic [rfdw_pkg::SERIAL_W-1:0]     serial,
    input  wire logic [rfdw_pkg::STATUS_W-1:0]     status,
    input  wire logic signed [rfdw_pkg::RSSI_W-1:0] rssi,
    input  wire logic [rfdw_pkg::TIME_W-1:0]       now_us,
    input  wire logic [rfdw_pkg::STATE_W-1:0]      radio_state,
    input  wire rfdw_pkg::cfg_t                    cfg,
    input  wire logic                              q_full,
    output logic                                   q_push,
    output rfdw_pkg::job_t                         q_data
);
    import rfdw_pkg::*;

    logic [TIME_W-1:0] last_reg;
    logic [TIME_W-1:0] last_next;
    logic [TIME_W-1:0] silence;
    logic              faint;
    logic              reinit;
    logic              kick;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    assign silence = now_us - last_reg;
    assign faint   = !req_type && (rssi < cfg.rssi_threshold);
    assign reinit  = req_type && cfg.watchdog_enable
                     && (silence > {{(TIME_W-WDOG_W){1'b0}}, cfg.watchdog_us});
    assign kick    = req_type && !reinit && (radio_state != cfg.rx_state_code);

    always_comb
    begin
        q_data.scan   = !req_type && !faint;
        q_data.serial = serial;
        q_data.status = status;
        q_data.rssi   = rssi;
        q_data.now_us = now_us;
        if (req_type)
        begin
            if (reinit)
                q_data.act = ACT_REINIT;
            else if (kick)
                q_data.act = ACT_KICK;
            else
                q_data.act = ACT_IDLE;
        end
        else if (faint)
        begin
            q_data.act = ACT_WEAK;
        end
        else
        begin
            q_data.act = ACT_FWD;
        end
    end

    always_comb
    begin
        last_next = last_reg;
        if (q_push && ((!req_type && !faint) || reinit))
            last_next = now_us;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= '0;
        else
            last_reg <= last_next;
    end

endmodule
`default_nettype wire

FILE: src/rfdw_fifo.sv
// Short job queue between front end and back end
`default_nettype none
module rfdw_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire rfdw_pkg::job_t push_data,
    output logic                full,
    input  wire logic           pop,
    output rfdw_pkg::job_t      pop_data,
    output logic                empty
);
    import rfdw_pkg::*;

    job_t               store_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wptr_reg;
    logic [Q_PTR_W-1:0] rptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: src/rfdw_back.sv
// Back end: scans packet history one entry per cycle, records new packets, drives results
`default_nettype none
module rfdw_back #(
    parameter int DEPTH = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire rfdw_pkg::cfg_t                     cfg,
    input  wire logic                               q_empty,
    input  wire rfdw_pkg::job_t                     q_data,
    output logic                                    q_pop,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [rfdw_pkg::ACTION_W-1:0]           action,
    output logic [rfdw_pkg::SERIAL_W-1:0]           out_serial,
    output logic [rfdw_pkg::STATUS_W-1:0]           out_status,
    output logic signed [rfdw_pkg::RSSI_W-1:0]      out_rssi
);
    import rfdw_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    hist_t                    mem [DEPTH];
    hist_t                    mem_q_reg;
    state_t                   state_reg;
    job_t                     job_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     cmp_valid_reg;
    logic                     dup_reg;
    logic [DEPTH-1:0]         valid_reg;
    logic [IDX_W-1:0]         wptr_reg;
    logic                     out_valid_reg;
    action_t                  action_reg;
    logic [SERIAL_W-1:0]      serial_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic signed [RSSI_W-1:0] rssi_reg;

    logic              out_free;
    logic              out_load;
    logic              issue;
    logic [IDX_W-1:0]  rd_addr;
    logic [TIME_W-1:0] age;
    logic              hit;
    logic              wr_en;
    hist_t             wr_entry;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty && (q_data.scan || out_free);
    assign out_load = ((state_reg == ST_IDLE) && q_pop && !q_data.scan)
                      || ((state_reg == ST_FINISH) && out_free);
    assign issue    = (state_reg == ST_SCAN) && (cnt_reg < CNT_W'(DEPTH));
    assign rd_addr  = cnt_reg[IDX_W-1:0];

    assign age = job_reg.now_us - mem_q_reg.stamp;
    assign hit = cmp_valid_reg && valid_reg[cmp_idx_reg]
                 && (mem_q_reg.serial == job_reg.serial)
                 && ((age < {{(TIME_W-WINDOW_W){1'b0}}, cfg.burst_window_us})
                     || ((mem_q_reg.status == job_reg.status)
                         && (age < {{(TIME_W-WINDOW_W){1'b0}}, cfg.long_window_us})));

    assign wr_en           = (state_reg == ST_FINISH) && out_free && !dup_reg;
    assign wr_entry.serial = job_reg.serial;
    assign wr_entry.status = job_reg.status;
    assign wr_entry.stamp  = job_reg.now_us;

    assign out_valid  = out_valid_reg;
    assign action     = action_reg;
    assign out_serial = serial_reg;
    assign out_status = status_reg;
    assign out_rssi   = rssi_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wptr_reg] <= wr_entry;
        if (issue)
            mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_data.scan)
            job_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cmp_idx_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            dup_reg       <= 1'b0;
            valid_reg     <= '0;
            wptr_reg      <= '0;
            out_valid_reg <= 1'b0;
            action_reg    <= ACT_IDLE;
            serial_reg    <= '0;
            status_reg    <= '0;
            rssi_reg      <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            cmp_valid_reg <= issue;
            cmp_idx_reg   <= rd_addr;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (q_data.scan)
                        begin
                            cnt_reg   <= '0;
                            dup_reg   <= 1'b0;
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            action_reg    <= q_data.act;
                            serial_reg    <= '0;
                            status_reg    <= '0;
                            rssi_reg      <= '0;
                        end
                    end
                end
                ST_SCAN:
                begin
                    dup_reg <= dup_reg || hit;
                    if (issue)
                        cnt_reg <= cnt_reg + 1'b1;
                    else
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg     <= ST_IDLE;
                        if (dup_reg)
                        begin
                            action_reg <= ACT_DUP;
                            serial_reg <= '0;
                            status_reg <= '0;
                            rssi_reg   <= '0;
                        end
                        else
                        begin
                            action_reg          <= ACT_FWD;
                            serial_reg          <= job_reg.serial;
                            status_reg          <= job_reg.status;
                            rssi_reg            <= job_reg.rssi;
                            valid_reg[wptr_reg] <= 1'b1;
                            if (wptr_reg == IDX_W'(DEPTH - 1))
                                wptr_reg <= '0;
                            else
                                wptr_reg <= wptr_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/rf_packet_dedup_watchdog_top.sv
// Top level of the RF packet duplicate filter and link watchdog
// Weak packets and health ticks pass through the job queue to the output register;
// packets that pass the RSSI check also wait in the back end for a scan of the history.
// Throughput: one weak packet or tick per cycle while the output is not stalled; a scanned
// packet holds the back end while its single history read port scans one entry per cycle.
// Reset: registers to defaults, history valid bits, job queue and silence timer cleared.
`default_nettype none
module rf_packet_dedup_watchdog_top #(
    parameter int HISTORY_DEPTH = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rfdw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rfdw_pkg::CFG_DAT_W-1:0]      cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                req_type,
    input  wire logic [rfdw_pkg::SERIAL_W-1:0]       serial,
    input  wire logic [rfdw_pkg::STATUS_W-1:0]       status,
    input  wire logic signed [rfdw_pkg::RSSI_W-1:0]  rssi,
    input  wire logic [rfdw_pkg::TIME_W-1:0]         now_us,
    input  wire logic [rfdw_pkg::STATE_W-1:0]        radio_state,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [rfdw_pkg::ACTION_W-1:0]            action,
    output logic [rfdw_pkg::SERIAL_W-1:0]            out_serial,
    output logic [rfdw_pkg::STATUS_W-1:0]            out_status,
    output logic signed [rfdw_pkg::RSSI_W-1:0]       out_rssi
);
    import rfdw_pkg::*;

    cfg_t cfg_reg;
    job_t push_data;
    job_t pop_data;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rssi_threshold  <= RST_RSSI_THR;
            cfg_reg.burst_window_us <= RST_BURST_WIN;
            cfg_reg.long_window_us  <= RST_LONG_WIN;
            cfg_reg.watchdog_us     <= RST_WDOG;
            cfg_reg.watchdog_enable <= RST_WDOG_EN;
            cfg_reg.rx_state_code   <= RST_RX_STATE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RSSI_THR:  cfg_reg.rssi_threshold  <= cfg_data[RSSI_W-1:0];
                REG_BURST_WIN: cfg_reg.burst_window_us <= cfg_data[WINDOW_W-1:0];
                REG_LONG_WIN:  cfg_reg.long_window_us  <= cfg_data[WINDOW_W-1:0];
                REG_WDOG:      cfg_reg.watchdog_us     <= cfg_data[WDOG_W-1:0];
                REG_WDOG_EN:   cfg_reg.watchdog_enable <= cfg_data[0];
                REG_RX_STATE:  cfg_reg.rx_state_code   <= cfg_data[STATE_W-1:0];
                default:       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    rfdw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .serial      (serial),
        .status      (status),
        .rssi        (rssi),
        .now_us      (now_us),
        .radio_state (radio_state),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (push_data)
    );

    rfdw_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    rfdw_back #(
        .DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_data     (pop_data),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .action     (action),
        .out_serial (out_serial),
        .out_status (out_status),
        .out_rssi   (out_rssi)
    );

endmodule
`default_nettype wire

FILE: src/rfdw_checker.sv
// Port-level checker for the duplicate filter top level, with its bind
`default_nettype none
module rfdw_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                out_valid,
    input wire logic                                out_stall,
    input wire logic [rfdw_pkg::ACTION_W-1:0]       action,
    input wire logic [rfdw_pkg::SERIAL_W-1:0]       out_serial,
    input wire logic [rfdw_pkg::STATUS_W-1:0]       out_status,
    input wire logic signed [rfdw_pkg::RSSI_W-1:0]  out_rssi
);
    import rfdw_pkg::*;

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result withdrawn");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(action) && $stable(out_serial)
                                   && $stable(out_status) && $stable(out_rssi))
        else $error("stalled result changed");

    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action != ACT_FWD) |->
            (out_serial == '0) && (out_status == '0) && (out_rssi == '0))
        else $error("packet fields set on a non-forward result");

endmodule

bind rf_packet_dedup_watchdog_top rfdw_checker u_rfdw_checker (.*);
`default_nettype wire

FILE: tb/rf_packet_dedup_watchdog_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the RF packet duplicate filter and link watchdog
module rf_packet_dedup_watchdog_top_tb;
    import rfdw_pkg::*;

    localparam int    HIST_DEPTH   = 8;
    localparam int    CLK_PERIOD   = 10;
    localparam int    RESET_CYCLES = 9;
    localparam int    TAIL_CYCLES  = 4 * (HIST_DEPTH + 3);
    localparam int    DRAIN_LIMIT  = 20000;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    PHASE_ITEMS  = 215;
    localparam int    POOL_SIZE    = 5;
    localparam longint TIMEOUT_NS  = 2_000_000;

    localparam logic                 REQ_PACKET   = 1'b0;
    localparam logic                 REQ_TICK     = 1'b1;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
    localparam logic [TIME_W-1:0]    TIME_MAX     = '1;

    typedef struct packed {
        logic                kind;
        logic [SERIAL_W-1:0] serial;
        logic [STATUS_W-1:0] status;
        logic [RSSI_W-1:0]   rssi;
        logic [TIME_W-1:0]   now;
        logic [STATE_W-1:0]  radio;
    } rf_req_t;

    typedef struct packed {
        action_t             act;
        logic [SERIAL_W-1:0] serial;
        logic [STATUS_W-1:0] status;
        logic [RSSI_W-1:0]   rssi;
    } verdict_t;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        cfg_valid   = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index   = '0;
    logic [CFG_DAT_W-1:0]        cfg_data    = '0;
    logic                        in_valid    = 1'b0;
    logic                        in_stall;
    logic                        req_type    = 1'b0;
    logic [SERIAL_W-1:0]         serial      = '0;
    logic [STATUS_W-1:0]         status      = '0;
    logic signed [RSSI_W-1:0]    rssi        = '0;
    logic [TIME_W-1:0]           now_us      = '0;
    logic [STATE_W-1:0]          radio_state = '0;
    logic                        out_valid;
    logic                        out_stall   = 1'b0;
    logic [ACTION_W-1:0]         action;
    logic [SERIAL_W-1:0]         out_serial;
    logic [STATUS_W-1:0]         out_status;
    logic signed [RSSI_W-1:0]    out_rssi;

    logic signed [RSSI_W-1:0]    thr_dbm;
    logic [WINDOW_W-1:0]         burst_win;
    logic [WINDOW_W-1:0]         long_win;
    logic [WDOG_W-1:0]           wdog_lim;
    logic                        wdog_on;
    logic [STATE_W-1:0]          rx_code;

    logic [SERIAL_W-1:0]         h_serial [HIST_DEPTH];
    logic [STATUS_W-1:0]         h_status [HIST_DEPTH];
    logic [TIME_W-1:0]           h_stamp  [HIST_DEPTH];
    logic                        h_valid  [HIST_DEPTH];
    int unsigned                 h_wr;
    logic [TIME_W-1:0]           last_heard;

    verdict_t                    pending_verdicts [$];
    int                          mismatch_count = 0;
    int                          tx_idle_pct    = 0;
    int                          rx_stall_pct   = 0;
    int                          hold_left      = 0;
    logic [TIME_W-1:0]           sim_now        = '0;
    logic [SERIAL_W-1:0]         serial_pool [POOL_SIZE];
    logic [STATUS_W-1:0]         status_pool [2];

    rf_packet_dedup_watchdog_top #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .serial      (serial),
        .status      (status),
        .rssi        (rssi),
        .now_us      (now_us),
        .radio_state (radio_state),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .action      (action),
        .out_serial  (out_serial),
        .out_status  (out_status),
        .out_rssi    (out_rssi)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void reset_model();
        thr_dbm   = RST_RSSI_THR;
        burst_win = RST_BURST_WIN;
        long_win  = RST_LONG_WIN;
        wdog_lim  = RST_WDOG;
        wdog_on   = RST_WDOG_EN;
        rx_code   = RST_RX_STATE;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            h_serial[i] = '0;
            h_status[i] = '0;
            h_stamp[i]  = '0;
            h_valid[i]  = 1'b0;
        end
        h_wr       = 0;
        last_heard = '0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        case (idx)
            REG_RSSI_THR:  thr_dbm   = data[RSSI_W-1:0];
            REG_BURST_WIN: burst_win = data[WINDOW_W-1:0];
            REG_LONG_WIN:  long_win  = data[WINDOW_W-1:0];
            REG_WDOG:      wdog_lim  = data[WDOG_W-1:0];
            REG_WDOG_EN:   wdog_on   = data[0];
            REG_RX_STATE:  rx_code   = data[STATE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic verdict_t judge_request(rf_req_t r);
        verdict_t          v;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] silence;
        logic              seen;
        v = '0;
        v.act = ACT_IDLE;
        if (r.kind == REQ_PACKET)
        begin
            if ($signed(r.rssi) < thr_dbm)
                v.act = ACT_WEAK;
            else
            begin
                last_heard = r.now;
                seen = 1'b0;
                for (int i = 0; i < HIST_DEPTH; i++)
                begin
                    if (!seen && h_valid[i] && h_serial[i] == r.serial)
                    begin
                        age = r.now - h_stamp[i];
                        if (age < burst_win || (h_status[i] == r.status && age < long_win))
                            seen = 1'b1;
                    end
                end
                if (seen)
                    v.act = ACT_DUP;
                else
                begin
                    h_serial[h_wr] = r.serial;
                    h_status[h_wr] = r.status;
                    h_stamp[h_wr]  = r.now;
                    h_valid[h_wr]  = 1'b1;
                    h_wr           = (h_wr + 1) % HIST_DEPTH;
                    v.act    = ACT_FWD;
                    v.serial = r.serial;
                    v.status = r.status;
                    v.rssi   = r.rssi;
                end
            end
        end
        else
        begin
            silence = r.now - last_heard;
            if (wdog_on && silence > wdog_lim)
            begin
                last_heard = r.now;
                v.act = ACT_REINIT;
            end
            else if (r.radio != rx_code)
                v.act = ACT_KICK;
        end
        return v;
    endfunction

    function automatic rf_req_t mk_packet(logic [SERIAL_W-1:0] ser, logic [STATUS_W-1:0] st,
                                          logic [RSSI_W-1:0] dbm, logic [TIME_W-1:0] at);
        rf_req_t r;
        r        = '0;
        r.kind   = REQ_PACKET;
        r.serial = ser;
        r.status = st;
        r.rssi   = dbm;
        r.now    = at;
        r.radio  = 8'($urandom());
        return r;
    endfunction

    function automatic rf_req_t mk_tick(logic [TIME_W-1:0] at, logic [STATE_W-1:0] radio);
        rf_req_t r;
        r        = '0;
        r.kind   = REQ_TICK;
        r.serial = 20'($urandom());
        r.status = 8'($urandom());
        r.rssi   = 8'($urandom());
        r.now    = at;
        r.radio  = radio;
        return r;
    endfunction

    function automatic void refresh_pools();
        for (int k = 0; k < POOL_SIZE; k++)
            serial_pool[k] = 20'($urandom());
        status_pool[0] = 8'($urandom());
        status_pool[1] = 8'($urandom());
    endfunction

    function automatic rf_req_t gen_request();
        rf_req_t           r;
        logic [TIME_W-1:0] hop;
        int                lo;
        int unsigned       pick;
        r    = '0;
        hop  = '0;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            hop = TIME_W'($urandom_range(0, burst_win));
        else if (pick < 60)
            hop = TIME_W'($urandom_range(0, long_win));
        else if (pick < 72)
            hop = TIME_W'(long_win) + TIME_W'($urandom_range(0, 4000000));
        else if (pick < 84)
            hop = {14'd0, 2'($urandom_range(0, 3)), 32'($urandom())};
        else if (pick < 92)
            sim_now = sim_now - TIME_W'($urandom_range(1, 2000000));
        else
            sim_now = {16'($urandom()), 32'($urandom())};
        sim_now = sim_now + hop;

        r.kind   = ($urandom_range(0, 99) < 18) ? REQ_TICK : REQ_PACKET;
        r.serial = ($urandom_range(0, 3) != 0) ? serial_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                : 20'($urandom());
        r.status = ($urandom_range(0, 9) < 7) ? status_pool[$urandom_range(0, 1)]
                                               : 8'($urandom());
        lo   = int'(thr_dbm);
        pick = $urandom_range(0, 99);
        if (pick < 75)
            r.rssi = 8'(lo + int'($urandom_range(0, 127 - lo)));
        else if (pick < 80)
            r.rssi = 8'(lo - 1);
        else
            r.rssi = 8'($urandom());
        r.radio = ($urandom_range(0, 1) != 0) ? rx_code : 8'($urandom());
        // land ticks on either side of the silence limit
        if (r.kind == REQ_TICK && $urandom_range(0, 99) < 35)
            sim_now = last_heard + TIME_W'(wdog_lim) + TIME_W'($urandom_range(0, 2))
                      - TIME_W'(1);
        r.now = sim_now;
        return r;
    endfunction

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
    endtask

    task automatic load_regs(input logic [CFG_DAT_W-1:0] thr, input logic [CFG_DAT_W-1:0] burst,
                             input logic [CFG_DAT_W-1:0] lng, input logic [CFG_DAT_W-1:0] wdog,
                             input logic [CFG_DAT_W-1:0] en, input logic [CFG_DAT_W-1:0] rx);
        write_reg(REG_RSSI_THR, thr);
        write_reg(REG_BURST_WIN, burst);
        write_reg(REG_LONG_WIN, lng);
        write_reg(REG_WDOG, wdog);
        write_reg(REG_WDOG_EN, en);
        write_reg(REG_RX_STATE, rx);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input rf_req_t r);
        in_valid    <= 1'b1;
        req_type    <= r.kind;
        serial      <= r.serial;
        status      <= r.status;
        rssi        <= r.rssi;
        now_us      <= r.now;
        radio_state <= r.radio;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_verdicts.push_back(judge_request(r));
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_verdicts.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_verdicts.size());
            mismatch_count++;
            pending_verdicts.delete();
        end
    endtask

    task automatic test_packet_rules();
        set_idling(0, 0);
        send_item(mk_tick(48'd0, RST_RX_STATE));
        send_item(mk_tick(48'd0, 8'h00));
        send_item(mk_tick(48'd0, 8'hFF));
        send_item(mk_packet(20'hFFFFF, 8'hFF, -8'sd128, 48'd10));
        send_item(mk_packet(20'h12345, 8'h5A, -8'sd101, 48'd20));
        send_item(mk_packet(20'h00000, 8'h00, 8'sd127, 48'd1000));
        send_item(mk_packet(20'h00000, 8'h00, 8'sd127, 48'd1100));
        send_item(mk_packet(20'h00000, 8'h00, 8'sd0, 48'd401000));
        send_item(mk_packet(20'h00000, 8'h01, 8'sd0, 48'd401000));
        send_item(mk_packet(20'hFFFFF, 8'hFF, RST_RSSI_THR, TIME_MAX));
        send_item(mk_packet(20'hFFFFF, 8'hFF, 8'sd5, 48'd5));
        send_item(mk_packet(20'h00000, 8'h01, 8'sd5, 48'd0));
        send_item(mk_packet(20'h00000, 8'h00, 8'sd9, 48'd3000000));
        send_item(mk_tick(48'd3000000 + 48'd5400000001, RST_RX_STATE));
        send_item(mk_tick(48'd3000000 + 48'd5400000002, 8'h00));
        drain_results();
    endtask

    task automatic test_register_writes();
        write_reg(IDX_SPARE_LO, '1);
        write_reg(IDX_SPARE_HI, '1);
        load_regs(40'hFF_FFFF_FF7F, 40'h0, 40'h0, 40'h0, 40'h1, 40'hFF);
        send_item(mk_packet(20'hABCDE, 8'h3C, 8'sd126, 48'd500));
        send_item(mk_packet(20'hABCDE, 8'h3C, 8'sd127, 48'd500));
        send_item(mk_packet(20'hABCDE, 8'h3C, 8'sd127, 48'd500));
        send_item(mk_tick(48'd501, 8'h00));
        send_item(mk_tick(48'd501, 8'h00));
        send_item(mk_tick(48'd501, 8'hFF));
        drain_results();
        load_regs(40'hFF_FFFF_FF80, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF,
                  40'hFF_FFFF_FFFE, 40'h0);
        send_item(mk_packet(20'hABCDE, 8'h00, -8'sd128, 48'd900));
        send_item(mk_tick(TIME_MAX, 8'h00));
        send_item(mk_tick(TIME_MAX, 8'h01));
        drain_results();
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    load_regs(CFG_DAT_W'(RST_RSSI_THR), CFG_DAT_W'(RST_BURST_WIN),
                              CFG_DAT_W'(RST_LONG_WIN), CFG_DAT_W'(RST_WDOG),
                              CFG_DAT_W'(RST_WDOG_EN), CFG_DAT_W'(RST_RX_STATE));
                    set_idling(0, 0);
                end
                1:
                begin
                    load_regs({8'($urandom()), 32'($urandom())},
                              CFG_DAT_W'($urandom_range(0, 1000000)),
                              CFG_DAT_W'($urandom_range(0, 4000000)),
                              CFG_DAT_W'($urandom_range(0, 3000000)),
                              40'($urandom()), 40'($urandom()));
                    set_idling(65, 0);
                end
                2:
                begin
                    load_regs(40'h80, 40'h0, 40'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 40'h1, 40'hFF);
                    set_idling(0, 65);
                end
                default:
                begin
                    load_regs(CFG_DAT_W'($urandom_range(0, 255)),
                              CFG_DAT_W'($urandom_range(0, 200000)),
                              CFG_DAT_W'($urandom_range(0, 3000000)),
                              CFG_DAT_W'($urandom_range(0, 500000)), 40'h1, 40'h0);
                    set_idling(20, 20);
                end
            endcase
            refresh_pools();
            repeat (PHASE_ITEMS)
                send_item(gen_request());
            drain_results();
        end
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        refresh_pools();
        hold_left = HOLD_CYCLES;
        repeat (40)
            send_item(gen_request());
        drain_results();
        set_idling(20, 20);
        repeat (30)
            send_item(gen_request());
        drain_results();
    endtask

    // hold the output off for a counted stretch, else stall at random
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= (rx_stall_pct != 0) && ($urandom_range(0, 99) < rx_stall_pct);
    end

    always @(posedge clk)
    begin
        verdict_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: result transfer with no expectation, action %0d", $time, action);
                mismatch_count++;
            end
            else
            begin
                due = pending_verdicts.pop_front();
                if (action !== due.act)
                begin
                    $display("%0t: action expected %0d, got %0d", $time, due.act, action);
                    mismatch_count++;
                end
                if (out_serial !== due.serial)
                begin
                    $display("%0t: out_serial expected 0x%05h, got 0x%05h",
                             $time, due.serial, out_serial);
                    mismatch_count++;
                end
                if (out_status !== due.status)
                begin
                    $display("%0t: out_status expected 0x%02h, got 0x%02h",
                             $time, due.status, out_status);
                    mismatch_count++;
                end
                if (out_rssi !== due.rssi)
                begin
                    $display("%0t: out_rssi expected %0d, got %0d",
                             $time, $signed(due.rssi), out_rssi);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        reset_model();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_packet_rules();
        test_register_writes();
        test_random_traffic();
        test_backpressure();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/rfdw_pkg.sv
src/rfdw_front.sv
src/rfdw_fifo.sv
src/rfdw_back.sv
src/rf_packet_dedup_watchdog_top.sv
src/rfdw_checker.sv
tb/rf_packet_dedup_watchdog_top_tb.sv
